// ----- rtl/core/mls_pkg.sv -----
// ---------------------------------------------------------------------------
// mls_pkg
// shared types, constants and the debug palette of the mip level selector
// ---------------------------------------------------------------------------
package mls_pkg;

    localparam int LEVELS          = 12;
    localparam int DERIV_FRAC_BITS = 20;

    localparam int DERIV_W = 24;
    localparam int TEX_W   = 15;
    localparam int LEVEL_W = 4;
    localparam int COL_W   = 9;

    // scaled derivative and its square
    localparam int PROD_W  = DERIV_W + TEX_W - 1;   // magnitude <= 2^23, tex < 2^15
    localparam int HALF_W  = (PROD_W + 1) / 2;
    localparam int SQ_W    = 2 * PROD_W;
    localparam int L_W     = SQ_W + 1;

    localparam logic [TEX_W-1:0] TEX_WIDTH_RST  = TEX_W'(1000);
    localparam logic [TEX_W-1:0] TEX_HEIGHT_RST = TEX_W'(100);

    typedef enum logic {
        t_REG_TEX_WIDTH  = 1'b0,
        t_REG_TEX_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic pp;    // partial product stage advances
        logic sum;   // assembly stage advances
    } t_sq_en;

    typedef struct packed {
        logic [COL_W-1:0] red;
        logic [COL_W-1:0] green;
        logic [COL_W-1:0] blue;
    } t_rgb;

    function automatic t_rgb palette(input logic [LEVEL_W-1:0] idx);
        t_rgb c;
        case (idx)
            4'd0:    c = '{9'd256, 9'd0,   9'd0};
            4'd1:    c = '{9'd0,   9'd0,   9'd256};
            4'd2:    c = '{9'd256, 9'd128, 9'd0};
            4'd3:    c = '{9'd256, 9'd0,   9'd128};
            4'd4:    c = '{9'd0,   9'd128, 9'd128};
            4'd5:    c = '{9'd0,   9'd64,  9'd128};
            4'd6:    c = '{9'd64,  9'd128, 9'd0};
            4'd7:    c = '{9'd128, 9'd0,   9'd256};
            4'd8:    c = '{9'd256, 9'd64,  9'd128};
            4'd9:    c = '{9'd128, 9'd128, 9'd128};
            4'd10:   c = '{9'd64,  9'd64,  9'd64};
            default: c = '{9'd32,  9'd32,  9'd32};
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/core/mls_in_if.sv -----
// ---------------------------------------------------------------------------
// mls_in_if
// derivative beat channel: valid, ready and the four texture derivatives
// ---------------------------------------------------------------------------
interface mls_in_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [mls_pkg::DERIV_W-1:0]        du_dx;
    logic signed [mls_pkg::DERIV_W-1:0]        dv_dx;
    logic signed [mls_pkg::DERIV_W-1:0]        du_dy;
    logic signed [mls_pkg::DERIV_W-1:0]        dv_dy;

    modport source (output valid, du_dx, dv_dx, du_dy, dv_dy, input ready);
    modport sink   (input valid, du_dx, dv_dx, du_dy, dv_dy, output ready);
endinterface

// ----- rtl/core/mls_out_if.sv -----
// ---------------------------------------------------------------------------
// mls_out_if
// result beat channel: level, clamp flag and palette colour
// ---------------------------------------------------------------------------
interface mls_out_if;
    logic                              valid;
    logic                              ready;
    logic [mls_pkg::LEVEL_W-1:0]       level;
    logic                              level_clamped;
    logic [mls_pkg::COL_W-1:0]         red;
    logic [mls_pkg::COL_W-1:0]         green;
    logic [mls_pkg::COL_W-1:0]         blue;

    modport source (output valid, level, level_clamped, red, green, blue, input ready);
    modport sink   (input valid, level, level_clamped, red, green, blue, output ready);
endinterface

// ----- rtl/core/mls_square.sv -----
// ---------------------------------------------------------------------------
// mls_square
// two-stage pipelined squarer: split partial products, then assembly
// ---------------------------------------------------------------------------
module mls_square (
    input  logic                         i_clk,
    input  mls_pkg::t_sq_en              i_en,
    input  logic [mls_pkg::PROD_W-1:0]   i_x,
    output logic [mls_pkg::SQ_W-1:0]     o_sq
);

    localparam int H  = mls_pkg::HALF_W;
    localparam int LW = mls_pkg::PROD_W - H;

    logic [H-1:0]         w_xh;
    logic [H-1:0]         w_xl;
    logic [2*H-1:0]       r_hh;
    logic [2*H-1:0]       r_hl;
    logic [2*H-1:0]       r_ll;
    logic [mls_pkg::SQ_W-1:0] r_sq;

    assign w_xh = H'(i_x >> LW);
    assign w_xl = H'(i_x[LW-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_en.pp) begin
            r_hh <= (2*H)'(w_xh) * (2*H)'(w_xh);
            r_hl <= (2*H)'(w_xh) * (2*H)'(w_xl);
            r_ll <= (2*H)'(w_xl) * (2*H)'(w_xl);
        end
    end

    // x^2 = hh * 2^(2*lw) + 2 * hl * 2^lw + ll
    always_ff @(posedge i_clk) begin
        if (i_en.sum) begin
            r_sq <= (mls_pkg::SQ_W'(r_hh) << (2*LW))
                  + (mls_pkg::SQ_W'(r_hl) << (LW+1))
                  +  mls_pkg::SQ_W'(r_ll);
        end
    end

    assign o_sq = r_sq;

endmodule

// ----- rtl/core/mipmap_level_select_top.sv -----
// ---------------------------------------------------------------------------
// mipmap_level_select_top
// mip level select: scaled derivative footprint, level decision, debug palette
// ---------------------------------------------------------------------------
// an accepted input beat passes magnitude, scale, square, footprint, threshold and level stages in order
// throughput: one beat per cycle while the output is not stalled; the stage chain has no loop
// each stage holds when its successor is full and stalled, so bubbles collapse
// reset (synchronous, active low) empties every stage and loads the texture
// size registers with 1000 by 100
module mipmap_level_select_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [mls_pkg::TEX_W-1:0]     i_cfg_data,
    mls_in_if.sink                        i_in,
    mls_out_if.source                     o_out
);

    localparam int NS = 7;     // register stages
    localparam int NL = mls_pkg::LEVELS;

    // configuration registers
    logic [mls_pkg::TEX_W-1:0] r_tex_w;
    logic [mls_pkg::TEX_W-1:0] r_tex_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_w <= mls_pkg::TEX_WIDTH_RST;
            r_tex_h <= mls_pkg::TEX_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (mls_pkg::t_cfg_reg'(i_cfg_idx))
                mls_pkg::t_REG_TEX_WIDTH:  r_tex_w <= i_cfg_data;
                mls_pkg::t_REG_TEX_HEIGHT: r_tex_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage valids and advance enables; a stage moves when empty or when
    // the next stage moves
    logic [NS-1:0] r_v;
    logic [NS-1:0] n_en;

    always_comb begin
        n_en[NS-1] = !r_v[NS-1] || o_out.ready;
        for (int s = NS-2; s >= 0; s--) begin
            n_en[s] = !r_v[s] || n_en[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (n_en[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (n_en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    assign i_in.ready = n_en[0];

    // stage 1: magnitudes, order du_dx, dv_dx, du_dy, dv_dy
    logic [mls_pkg::DERIV_W-1:0] w_raw [4];
    logic [mls_pkg::DERIV_W-1:0] r_mag [4];

    assign w_raw[0] = i_in.du_dx;
    assign w_raw[1] = i_in.dv_dx;
    assign w_raw[2] = i_in.du_dy;
    assign w_raw[3] = i_in.dv_dy;

    always_ff @(posedge i_clk) begin
        if (n_en[0]) begin
            for (int j = 0; j < 4; j++) begin
                // most negative value maps to 2^23, which still fits unsigned
                r_mag[j] <= w_raw[j][mls_pkg::DERIV_W-1] ? (~w_raw[j] + 1'b1) : w_raw[j];
            end
        end
    end

    // stage 2: scale u by width and v by height
    logic [mls_pkg::PROD_W-1:0] r_prod [4];

    always_ff @(posedge i_clk) begin
        if (n_en[1]) begin
            for (int j = 0; j < 4; j++) begin
                r_prod[j] <= mls_pkg::PROD_W'(r_mag[j])
                           * mls_pkg::PROD_W'((j % 2 == 0) ? r_tex_w : r_tex_h);
            end
        end
    end

    // stages 3 and 4: squares
    mls_pkg::t_sq_en            w_sq_en;
    logic [mls_pkg::SQ_W-1:0]   w_sq [4];

    assign w_sq_en.pp  = n_en[2];
    assign w_sq_en.sum = n_en[3];

    for (genvar j = 0; j < 4; j++) begin : g_sq
        mls_square u_sq (
            .i_clk (i_clk),
            .i_en  (w_sq_en),
            .i_x   (r_prod[j]),
            .o_sq  (w_sq[j])
        );
    end

    // stage 5: squared footprint length for the x step and the y step
    logic [mls_pkg::L_W-1:0] r_lx;
    logic [mls_pkg::L_W-1:0] r_ly;

    always_ff @(posedge i_clk) begin
        if (n_en[4]) begin
            r_lx <= mls_pkg::L_W'(w_sq[0]) + mls_pkg::L_W'(w_sq[1]);
            r_ly <= mls_pkg::L_W'(w_sq[2]) + mls_pkg::L_W'(w_sq[3]);
        end
    end

    // stage 6: level >= k exactly when the larger length has a set bit at or
    // above 2k + 2*frac - 1; or-ing both steps takes the maximum
    logic [NL-1:0] w_thr;
    logic [NL-1:0] r_thr;

    for (genvar k = 1; k <= NL; k++) begin : g_thr
        localparam int SH = 2*k + 2*mls_pkg::DERIV_FRAC_BITS - 1;
        assign w_thr[k-1] = |(r_lx >> SH) || |(r_ly >> SH);
    end

    always_ff @(posedge i_clk) begin
        if (n_en[5]) begin
            r_thr <= w_thr;
        end
    end

    // stage 7: thermometer to level, clamp to the top level, palette lookup
    logic [mls_pkg::LEVEL_W-1:0] n_level;
    logic                        n_clamped;
    mls_pkg::t_rgb               n_rgb;
    logic [mls_pkg::LEVEL_W-1:0] r_level;
    logic                        r_clamped;
    mls_pkg::t_rgb               r_rgb;

    always_comb begin
        n_level = '0;
        for (int k = 0; k < NL-1; k++) begin
            if (r_thr[k]) begin
                n_level = mls_pkg::LEVEL_W'(k + 1);
            end
        end
        n_clamped = r_thr[NL-1];
        if (n_clamped) begin
            n_level = mls_pkg::LEVEL_W'(NL - 1);
        end
        n_rgb = mls_pkg::palette(n_level);
    end

    always_ff @(posedge i_clk) begin
        if (n_en[6]) begin
            r_level   <= n_level;
            r_clamped <= n_clamped;
            r_rgb     <= n_rgb;
        end
    end

    assign o_out.valid         = r_v[NS-1];
    assign o_out.level         = r_level;
    assign o_out.level_clamped = r_clamped;
    assign o_out.red           = r_rgb.red;
    assign o_out.green         = r_rgb.green;
    assign o_out.blue          = r_rgb.blue;

endmodule

// ----- rtl/core/mls_checker.sv -----
// ---------------------------------------------------------------------------
// mls_checker
// port-level checks on the result beats of the mip level selector
// ---------------------------------------------------------------------------
module mls_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          i_ready,
    input logic [mls_pkg::LEVEL_W-1:0]   i_level,
    input logic                          i_clamped,
    input logic [mls_pkg::COL_W-1:0]     i_red,
    input logic [mls_pkg::COL_W-1:0]     i_green,
    input logic [mls_pkg::COL_W-1:0]     i_blue
);

    // level never past the top entry
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_level <= mls_pkg::LEVEL_W'(mls_pkg::LEVELS - 1)))
        else $error("level out of range");

    // a clamped beat sits on the top level
    a_clamp_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_clamped) |-> (i_level == mls_pkg::LEVEL_W'(mls_pkg::LEVELS - 1)))
        else $error("clamp flag without top level");

    // colour follows the level through the palette
    a_palette: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ({i_red, i_green, i_blue} == mls_pkg::palette(i_level)))
        else $error("colour does not match level");

    // no beat straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_valid)
        else $error("beat presented after reset");

    // a stalled beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_level) && $stable(i_clamped)))
        else $error("stalled beat changed");

endmodule

bind mipmap_level_select_top mls_checker u_mls_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_out.valid),
    .i_ready   (o_out.ready),
    .i_level   (o_out.level),
    .i_clamped (o_out.level_clamped),
    .i_red     (o_out.red),
    .i_green   (o_out.green),
    .i_blue    (o_out.blue)
);
